[rtl/baro_temp_press_compensation_core_macros.svh]
// Assertion macros for the compensation core.
`ifndef BARO_TEMP_PRESS_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_PRESS_COMPENSATION_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BTPC_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define BTPC_CHECK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BTPC_CHECK(lbl, cond, msg)
`define BTPC_CHECK_IMPLY(lbl, ante, cons, msg)
`endif

`endif

[rtl/btpc_pkg.sv]
package btpc_pkg;

  localparam int RawW      = 20;
  localparam int TempW     = 16;
  localparam int PressW    = 32;
  localparam int CoefW     = 48;
  localparam int RegIdxW   = 2;
  localparam int QuoW      = 64;
  localparam int DenW      = 31;
  localparam int DivBits   = 2;
  localparam int DivStages = QuoW / DivBits;

  localparam logic signed [TempW-1:0] TempMin = 16'sh8000;
  localparam logic signed [TempW-1:0] TempMax = 16'sh7fff;

  typedef enum logic [RegIdxW-1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeffs_t;

  typedef struct packed {
    logic [QuoW-1:0]         num_mag;
    logic [DenW-1:0]         den_mag;
    logic                    neg;
    logic                    nz;
    logic signed [TempW-1:0] temp_centi;
  } div_in_t;

  typedef struct packed {
    logic [QuoW-1:0]         quo;
    logic                    neg;
    logic                    nz;
    logic signed [TempW-1:0] temp_centi;
  } div_out_t;

  // low 64 bits of a * b, b taken as signed or unsigned 16-bit
  function automatic logic [63:0] mul_lo64_s16(input logic [63:0] a, input logic [15:0] b,
                                               input logic b_signed);
    logic [47:0] lo;
    logic [47:0] hi;
    logic [63:0] r;
    lo = a[31:0] * b;
    hi = a[63:32] * b;
    r = {16'b0, lo} + {hi[31:0], 32'b0};
    if (b_signed && b[15]) begin
      r = r - {a[47:0], 16'b0};
    end
    return r;
  endfunction

endpackage

[rtl/btpc_in_if.sv]
interface btpc_in_if import btpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temp;
  logic [RawW-1:0] raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

[rtl/btpc_out_if.sv]
interface btpc_out_if import btpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_centi;
  logic [PressW-1:0]       press_q24_8;
  logic                    press_valid;

  modport source (output valid, output temp_centi, output press_q24_8, output press_valid,
                  input ready);
  modport sink (input valid, input temp_centi, input press_q24_8, input press_valid,
                output ready);
endinterface

[rtl/baro_temp_press_compensation_core.sv]
// Channel   Dir  Payload                                      Transaction
// sample    in   raw_temp[19:0], raw_press[19:0]               valid & ready
// result    out  temp_centi[15:0], press_q24_8[31:0], press_valid   valid & ready
// cfg       in   cfg_index[1:0], cfg_data[47:0]                cfg_wr_en
//
// One transaction per cycle sustained while result is not stalled; 10 front stages,
// 32 divider stages (two quotient bits each), 6 back stages.
// Synchronous active-high reset clears the valid bits and the coefficient registers.
// Each stage holds while full and blocked downstream; bubbles are squeezed out,
// so sample.ready drops only when every stage is full and result is stalled.
`include "baro_temp_press_compensation_core_macros.svh"

module baro_temp_press_compensation_core import btpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  btpc_in_if.sink            sample,
  btpc_out_if.source         result,
  input  logic               cfg_wr_en,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CoefW-1:0]   cfg_data
);

  logic [CoefW-1:0] temp_coeffs;
  logic [CoefW-1:0] press_coeffs_a;
  logic [CoefW-1:0] press_coeffs_b;
  logic [CoefW-1:0] press_coeffs_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP:    temp_coeffs    <= cfg_data;
        REG_PRESS_A: press_coeffs_a <= cfg_data;
        REG_PRESS_B: press_coeffs_b <= cfg_data;
        REG_PRESS_C: press_coeffs_c <= cfg_data;
      endcase
    end
  end

  coeffs_t coef;

  assign coef.t1 = temp_coeffs[15:0];
  assign coef.t2 = temp_coeffs[31:16];
  assign coef.t3 = temp_coeffs[47:32];
  assign coef.p1 = press_coeffs_a[15:0];
  assign coef.p2 = press_coeffs_a[31:16];
  assign coef.p3 = press_coeffs_a[47:32];
  assign coef.p4 = press_coeffs_b[15:0];
  assign coef.p5 = press_coeffs_b[31:16];
  assign coef.p6 = press_coeffs_b[47:32];
  assign coef.p7 = press_coeffs_c[15:0];
  assign coef.p8 = press_coeffs_c[31:16];
  assign coef.p9 = press_coeffs_c[47:32];

  logic     fd_valid;
  logic     fd_ready;
  div_in_t  fd_data;
  logic     db_valid;
  logic     db_ready;
  div_out_t db_data;

  btpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .sample    (sample),
    .out_valid (fd_valid),
    .out_ready (fd_ready),
    .out_data  (fd_data)
  );

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fd_valid),
    .in_ready  (fd_ready),
    .in_data   (fd_data),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_data  (db_data)
  );

  btpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .in_valid (db_valid),
    .in_ready (db_ready),
    .in_data  (db_data),
    .result   (result)
  );

  `BTPC_CHECK(a_invalid_press_zero, !(result.valid && !result.press_valid) || result.press_q24_8 == '0, "pressure nonzero with zero divisor")
  `BTPC_CHECK_IMPLY(a_blocked_only_full, !sample.ready, result.valid && !result.ready, "input blocked while pipeline can move")
  `BTPC_CHECK_IMPLY(a_empty_after_reset, $past(rst), !result.valid, "result valid right after reset")

endmodule

[rtl/btpc_front.sv]
module btpc_front import btpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  coeffs_t       coef,
  btpc_in_if.sink       sample,
  output logic          out_valid,
  input  logic          out_ready,
  output div_in_t       out_data
);

  localparam int NStg = 10;

  logic [NStg-1:0] v;
  logic [NStg:0]   en;
  logic [NStg-1:0] v_prev;

  always_comb begin
    en[NStg] = out_ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_prev       = {v[NStg-2:0], sample.valid};
  assign sample.ready = en[0];
  assign out_valid    = v[NStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) v[k] <= v_prev[k];
      end
    end
  end

  // stage 1: temperature differences and first products
  logic signed [17:0] c1_a;
  logic signed [16:0] c1_d;
  logic signed [33:0] s1_m1;
  logic signed [33:0] s1_dd;
  logic [RawW-1:0]    s1_ap;

  assign c1_a = $signed({1'b0, sample.raw_temp[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
  assign c1_d = $signed({1'b0, sample.raw_temp[19:4]}) - $signed({1'b0, coef.t1});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_m1 <= c1_a * $signed(coef.t2);
      s1_dd <= c1_d * c1_d;
      s1_ap <= sample.raw_press;
    end
  end

  // stage 2
  logic signed [21:0] c2_dd12;
  logic signed [22:0] s2_v1;
  logic signed [37:0] s2_m2;
  logic [RawW-1:0]    s2_ap;

  assign c2_dd12 = $signed({1'b0, s1_dd[32:12]});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_v1 <= s1_m1[33:11];
      s2_m2 <= c2_dd12 * $signed(coef.t3);
      s2_ap <= s1_ap;
    end
  end

  // stage 3: t_fine
  logic signed [23:0] c3_v2;
  logic signed [24:0] s3_tfine;
  logic [RawW-1:0]    s3_ap;

  assign c3_v2 = s2_m2[37:14];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_tfine <= c3_v2 + s2_v1;
      s3_ap    <= s2_ap;
    end
  end

  // stage 4: temperature output, pressure offset
  logic signed [27:0]      c4_t5;
  logic signed [19:0]      c4_tc;
  logic signed [TempW-1:0] c4_temp;
  logic signed [25:0]      c4_w1;
  logic signed [TempW-1:0] s4_temp;
  logic signed [25:0]      s4_w1;
  logic [RawW-1:0]         s4_ap;

  assign c4_t5 = s3_tfine * 28'sd5 + 28'sd128;
  assign c4_tc = c4_t5[27:8];
  assign c4_w1 = s3_tfine - 26'sd128000;

  always_comb begin
    if (c4_tc < TempMin) begin
      c4_temp = TempMin;
    end else if (c4_tc > TempMax) begin
      c4_temp = TempMax;
    end else begin
      c4_temp = c4_tc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_temp <= c4_temp;
      s4_w1   <= c4_w1;
      s4_ap   <= s3_ap;
    end
  end

  // stage 5
  logic signed [51:0]      s5_sq;
  logic signed [41:0]      s5_m5;
  logic signed [41:0]      s5_m2p;
  logic signed [TempW-1:0] s5_temp;
  logic [RawW-1:0]         s5_ap;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_sq   <= s4_w1 * s4_w1;
      s5_m5   <= s4_w1 * $signed(coef.p5);
      s5_m2p  <= s4_w1 * $signed(coef.p2);
      s5_temp <= s4_temp;
      s5_ap   <= s4_ap;
    end
  end

  // stage 6
  logic signed [63:0]      c6_sq;
  logic [63:0]             s6_w2a;
  logic [63:0]             s6_w1a;
  logic signed [41:0]      s6_m5;
  logic signed [41:0]      s6_m2p;
  logic signed [TempW-1:0] s6_temp;
  logic [RawW-1:0]         s6_ap;

  assign c6_sq = s5_sq;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_w2a  <= mul_lo64_s16(c6_sq, coef.p6, 1'b1);
      s6_w1a  <= mul_lo64_s16(c6_sq, coef.p3, 1'b1);
      s6_m5   <= s5_m5;
      s6_m2p  <= s5_m2p;
      s6_temp <= s5_temp;
      s6_ap   <= s5_ap;
    end
  end

  // stage 7
  logic signed [63:0]      c7_m5;
  logic signed [63:0]      c7_m2p;
  logic signed [63:0]      c7_p4;
  logic signed [63:0]      c7_w1s;
  logic [63:0]             c7_w2;
  logic [63:0]             c7_base;
  logic [63:0]             s7_w2;
  logic [63:0]             s7_base;
  logic signed [TempW-1:0] s7_temp;
  logic [RawW-1:0]         s7_ap;

  assign c7_m5   = s6_m5;
  assign c7_m2p  = s6_m2p;
  assign c7_p4   = coef.p4;
  assign c7_w1s  = $signed(s6_w1a) >>> 8;
  assign c7_w2   = s6_w2a + (c7_m5 << 17) + (c7_p4 << 35);
  assign c7_base = c7_w1s + (c7_m2p << 12) + (64'd1 << 47);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_w2   <= c7_w2;
      s7_base <= c7_base;
      s7_temp <= s6_temp;
      s7_ap   <= s6_ap;
    end
  end

  // stage 8
  logic [20:0]             c8_pdiff;
  logic [63:0]             s8_prod;
  logic [63:0]             s8_num0;
  logic signed [TempW-1:0] s8_temp;

  assign c8_pdiff = 21'd1048576 - {1'b0, s7_ap};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_prod <= mul_lo64_s16(s7_base, coef.p1, 1'b0);
      s8_num0 <= ({43'b0, c8_pdiff} << 31) - s7_w2;
      s8_temp <= s7_temp;
    end
  end

  // stage 9: divisor and scaled numerator
  logic [DenW-1:0]         s9_den;
  logic [63:0]             s9_num;
  logic signed [TempW-1:0] s9_temp;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_den  <= s8_prod[63:33];
      s9_num  <= s8_num0 * 64'd3125;
      s9_temp <= s8_temp;
    end
  end

  // stage 10: magnitudes for the divider
  always_ff @(posedge clk) begin
    if (en[9]) begin
      out_data.neg        <= s9_num[63] ^ s9_den[DenW-1];
      out_data.num_mag    <= s9_num[63] ? 64'd0 - s9_num : s9_num;
      out_data.den_mag    <= s9_den[DenW-1] ? {DenW{1'b0}} - s9_den : s9_den;
      out_data.nz         <= s9_den != '0;
      out_data.temp_centi <= s9_temp;
    end
  end

endmodule

[rtl/btpc_div.sv]
module btpc_div import btpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output div_out_t out_data
);

  function automatic logic [DenW+QuoW-1:0] div_step(input logic [DenW-1:0] rem,
                                                    input logic [QuoW-1:0] dq,
                                                    input logic [DenW-1:0] den);
    logic [DenW:0]   r;
    logic [DenW-1:0] rm;
    logic [QuoW-1:0] q;
    rm = rem;
    q  = dq;
    for (int j = 0; j < DivBits; j++) begin
      r = {rm, q[QuoW-1]};
      q = {q[QuoW-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
      rm = r[DenW-1:0];
    end
    return {rm, q};
  endfunction

  logic [DivStages-1:0] v;
  logic [DivStages:0]   en;
  logic [DivStages-1:0] v_prev;

  logic [DenW-1:0]         rem_q  [DivStages];
  logic [QuoW-1:0]         dq_q   [DivStages];
  logic [DenW-1:0]         den_q  [DivStages];
  logic                    neg_q  [DivStages];
  logic                    nz_q   [DivStages];
  logic signed [TempW-1:0] temp_q [DivStages];

  always_comb begin
    en[DivStages] = out_ready;
    for (int k = DivStages - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_prev   = {v[DivStages-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (en[k]) v[k] <= v_prev[k];
      end
    end
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    logic [DenW-1:0]         rem_in;
    logic [QuoW-1:0]         dq_in;
    logic [DenW-1:0]         den_in;
    logic                    neg_in;
    logic                    nz_in;
    logic signed [TempW-1:0] temp_in;
    logic [DenW-1:0]         rem_nx;
    logic [QuoW-1:0]         dq_nx;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = in_data.num_mag;
      assign den_in  = in_data.den_mag;
      assign neg_in  = in_data.neg;
      assign nz_in   = in_data.nz;
      assign temp_in = in_data.temp_centi;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign den_in  = den_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign nz_in   = nz_q[s-1];
      assign temp_in = temp_q[s-1];
    end

    assign {rem_nx, dq_nx} = div_step(rem_in, dq_in, den_in);

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s]  <= rem_nx;
        dq_q[s]   <= dq_nx;
        den_q[s]  <= den_in;
        neg_q[s]  <= neg_in;
        nz_q[s]   <= nz_in;
        temp_q[s] <= temp_in;
      end
    end
  end

  assign out_valid           = v[DivStages-1];
  assign out_data.quo        = dq_q[DivStages-1];
  assign out_data.neg        = neg_q[DivStages-1];
  assign out_data.nz         = nz_q[DivStages-1];
  assign out_data.temp_centi = temp_q[DivStages-1];

endmodule

[rtl/btpc_back.sv]
module btpc_back import btpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  coeffs_t  coef,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_out_t in_data,
  btpc_out_if.source result
);

  localparam int NStg = 6;

  logic [NStg-1:0] v;
  logic [NStg:0]   en;
  logic [NStg-1:0] v_prev;

  always_comb begin
    en[NStg] = result.ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_prev       = {v[NStg-2:0], in_valid};
  assign in_ready     = en[0];
  assign result.valid = v[NStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) v[k] <= v_prev[k];
      end
    end
  end

  // stage 1: signed quotient
  logic [63:0]             b1_p;
  logic                    b1_nz;
  logic signed [TempW-1:0] b1_temp;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_p    <= in_data.neg ? 64'd0 - in_data.quo : in_data.quo;
      b1_nz   <= in_data.nz;
      b1_temp <= in_data.temp_centi;
    end
  end

  // stage 2: partial products of ps * ps, p8 * p
  logic [63:0]             c2_ps;
  logic [63:0]             b2_ll;
  logic [31:0]             b2_lh;
  logic [63:0]             b2_x4m;
  logic [63:0]             b2_p;
  logic                    b2_nz;
  logic signed [TempW-1:0] b2_temp;

  assign c2_ps = $signed(b1_p) >>> 13;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b2_ll   <= c2_ps[31:0] * c2_ps[31:0];
      b2_lh   <= c2_ps[31:0] * c2_ps[63:32];
      b2_x4m  <= mul_lo64_s16(b1_p, coef.p8, 1'b1);
      b2_p    <= b1_p;
      b2_nz   <= b1_nz;
      b2_temp <= b1_temp;
    end
  end

  // stage 3
  logic [63:0]             c3_x4;
  logic [63:0]             b3_pss;
  logic [63:0]             b3_x4;
  logic [63:0]             b3_p;
  logic                    b3_nz;
  logic signed [TempW-1:0] b3_temp;

  assign c3_x4 = $signed(b2_x4m) >>> 19;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b3_pss  <= b2_ll + {b2_lh[30:0], 33'b0};
      b3_x4   <= c3_x4;
      b3_p    <= b2_p;
      b3_nz   <= b2_nz;
      b3_temp <= b2_temp;
    end
  end

  // stage 4
  logic [63:0]             b4_x3m;
  logic [63:0]             b4_x4;
  logic [63:0]             b4_p;
  logic                    b4_nz;
  logic signed [TempW-1:0] b4_temp;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      b4_x3m  <= mul_lo64_s16(b3_pss, coef.p9, 1'b1);
      b4_x4   <= b3_x4;
      b4_p    <= b3_p;
      b4_nz   <= b3_nz;
      b4_temp <= b3_temp;
    end
  end

  // stage 5
  logic [63:0]             c5_x3;
  logic [63:0]             b5_sum;
  logic                    b5_nz;
  logic signed [TempW-1:0] b5_temp;

  assign c5_x3 = $signed(b4_x3m) >>> 25;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      b5_sum  <= b4_p + c5_x3 + b4_x4;
      b5_nz   <= b4_nz;
      b5_temp <= b4_temp;
    end
  end

  // stage 6: offset, clamp, output register
  logic [63:0]        c6_sh;
  logic signed [63:0] c6_p7;
  logic [63:0]        c6_p;
  logic [PressW-1:0]  c6_press;

  assign c6_sh = $signed(b5_sum) >>> 8;
  assign c6_p7 = coef.p7;
  assign c6_p  = c6_sh + (c6_p7 << 4);

  always_comb begin
    if (!b5_nz || c6_p[63]) begin
      c6_press = '0;
    end else if (c6_p[63:PressW] != '0) begin
      c6_press = '1;
    end else begin
      c6_press = c6_p[PressW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      result.temp_centi  <= b5_temp;
      result.press_q24_8 <= c6_press;
      result.press_valid <= b5_nz;
    end
  end

endmodule
